// ===== hdl/apq_pkg.sv =====
// apq_pkg: shared constants and types of the ascending priority queue
// no dependencies; used by the channel interfaces and the top level

package apq_pkg;

	localparam int DEPTH = 8;
	localparam int VAL_W = 32;
	localparam int OCC_W = 4;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [OCC_W-1:0] occ_t;

endpackage

// ===== hdl/apq_if.sv =====
// apq_if: valid/ready channel interfaces of the ascending priority queue
// depends on apq_pkg for payload types

interface apq_cmd_if;
	logic             valid;
	logic             ready;
	apq_pkg::action_t action;
	apq_pkg::value_t  value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface apq_rsp_if;
	logic             valid;
	logic             ready;
	apq_pkg::status_t status;
	apq_pkg::value_t  removed_value;
	apq_pkg::occ_t    occupancy;

	modport source (output valid, output status, output removed_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input removed_value, input occupancy,
		output ready);
endinterface

// ===== hdl/ascending_priority_queue.sv =====
// ascending_priority_queue: bounded min-first priority queue, top level
// depends on apq_pkg and the channel interfaces in apq_if.sv
//
// usage
// - cmd channel: action (insert or remove the smallest) and a signed value;
//   a transfer happens on a clock edge with valid and ready both high
// - rsp channel: one result per command with status, removed value (zero unless
//   a value was removed) and occupancy after the operation
// - a taken command waits in the input register and its result in the result
//   register; one command per cycle is sustained while the receiver keeps up
// - the rate is set by the single pass over the entry row: every cell compares
//   itself against the new value and takes its own, its left or its right
//   neighbor's value, or the new value
// - equal values leave in arrival order; insert into a full queue is dropped
//   with status full, remove on an empty queue reports status empty
// - reset clears the fill count and the valid flags; entry contents are left
//   as they are and never read before being written
// - when the receiver stalls the result register holds, the input register
//   holds one more command, and cmd ready falls until the result is taken

module ascending_priority_queue (
	input  logic            clk,
	input  logic            arst_n,
	apq_cmd_if.sink         cmd,
	apq_rsp_if.source       rsp
);

	// input register
	logic               valid_s1;
	apq_pkg::action_t   action_s1;
	apq_pkg::value_t    value_s1;

	// queue state
	apq_pkg::value_t    entries_q [apq_pkg::DEPTH];
	apq_pkg::count_t    fill_q;

	// result register
	logic               rsp_valid_q;
	apq_pkg::status_t   status_q;
	apq_pkg::value_t    removed_q;
	apq_pkg::occ_t      occ_q;

	// next-state of the single pass
	logic               advance;
	logic [apq_pkg::DEPTH-1:0] le;
	apq_pkg::value_t    entries_n [apq_pkg::DEPTH];
	apq_pkg::count_t    fill_n;
	apq_pkg::status_t   status_n;
	apq_pkg::value_t    removed_n;
	logic               is_full;
	logic               is_empty;

	// stage 1 moves on when the result register is free or being emptied
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	assign is_full  = (fill_q == apq_pkg::count_t'(apq_pkg::DEPTH));
	assign is_empty = (fill_q == '0);

	// cells holding entries not greater than the new value form a prefix
	always_comb begin
		for (int i = 0; i < apq_pkg::DEPTH; i++) begin
			le[i] = (apq_pkg::count_t'(i) < fill_q) && (entries_q[i] <= value_s1);
		end
	end

	always_comb begin
		for (int i = 0; i < apq_pkg::DEPTH; i++) begin
			entries_n[i] = entries_q[i];
		end
		fill_n    = fill_q;
		status_n  = apq_pkg::ST_INSERTED;
		removed_n = '0;
		case (action_s1)
			apq_pkg::ACT_INSERT: begin
				if (is_full) begin
					status_n = apq_pkg::ST_FULL;
				end else begin
					status_n = apq_pkg::ST_INSERTED;
					fill_n   = fill_q + apq_pkg::count_t'(1);
					// keep, take the new value at the insert point, or shift right
					for (int i = 0; i < apq_pkg::DEPTH; i++) begin
						if (le[i]) begin
							entries_n[i] = entries_q[i];
						end else if (i == 0) begin
							entries_n[i] = value_s1;
						end else if (le[i-1]) begin
							entries_n[i] = value_s1;
						end else begin
							entries_n[i] = entries_q[i-1];
						end
					end
				end
			end
			apq_pkg::ACT_REMOVE: begin
				if (is_empty) begin
					status_n = apq_pkg::ST_EMPTY;
				end else begin
					status_n  = apq_pkg::ST_REMOVED;
					removed_n = entries_q[0];
					fill_n    = fill_q - apq_pkg::count_t'(1);
					// everything moves one cell toward the head
					for (int i = 0; i < apq_pkg::DEPTH - 1; i++) begin
						entries_n[i] = entries_q[i+1];
					end
				end
			end
			default: begin
				status_n = apq_pkg::ST_EMPTY;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				fill_q      <= fill_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			action_s1 <= cmd.action;
			value_s1  <= cmd.value;
		end
		if (advance) begin
			for (int i = 0; i < apq_pkg::DEPTH; i++) begin
				entries_q[i] <= entries_n[i];
			end
			status_q  <= status_n;
			removed_q <= removed_n;
			occ_q     <= apq_pkg::occ_t'(fill_n);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q;
	assign rsp.occupancy     = occ_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= apq_pkg::count_t'(apq_pkg::DEPTH))
		else $error("fill count above depth");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status_n == apq_pkg::ST_REMOVED |=>
		fill_q == $past(fill_q) - apq_pkg::count_t'(1))
		else $error("remove did not lower the fill count");

	a_insert_inc: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status_n == apq_pkg::ST_INSERTED |=>
		fill_q == $past(fill_q) + apq_pkg::count_t'(1))
		else $error("insert did not raise the fill count");

	a_zero_removed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q != apq_pkg::ST_REMOVED |-> removed_q == '0)
		else $error("removed value nonzero without a removal");

	a_no_change_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> fill_q == $past(fill_q))
		else $error("fill count moved without an operation");

endmodule
